// ===== src/i2cma_pkg.sv =====
// Shared types and constants for the I2C register access master.
`timescale 1ns / 1ps

package i2cma_pkg;

    localparam int MAX_BYTES = 16;
    localparam int LEN_W     = 5;
    localparam int IDX_W     = 4;
    localparam int BIT_W     = 4;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_ST0  = 5'd1,
        PH_ST1  = 5'd2,
        PH_ST2  = 5'd3,
        PH_TX0  = 5'd4,
        PH_TX1  = 5'd5,
        PH_TX2  = 5'd6,
        PH_AK0  = 5'd7,
        PH_AK1  = 5'd8,
        PH_AK2  = 5'd9,
        PH_RX0  = 5'd10,
        PH_RX1  = 5'd11,
        PH_MA0  = 5'd12,
        PH_MA1  = 5'd13,
        PH_MA2  = 5'd14,
        PH_SP0  = 5'd15,
        PH_SP1  = 5'd16
    } t_phase;

    typedef enum logic [1:0] {
        SG_ADDR_W = 2'd0,
        SG_REG    = 2'd1,
        SG_DATA   = 2'd2,
        SG_ADDR_R = 2'd3
    } t_stage;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_last;
        logic       done_res;
        logic       status;
    } t_result;

endpackage

// ===== src/i2cma_if.sv =====
// Request and result channel interfaces for the I2C register access master.
`timescale 1ns / 1ps

interface i2cma_req_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   kind;
    logic [6:0]                   dev_addr;
    logic [7:0]                   reg_addr;
    logic [i2cma_pkg::LEN_W-1:0]  length;
    logic [i2cma_pkg::IDX_W-1:0]  buf_index;
    logic [7:0]                   data_byte;
    logic                         sda_in;

    modport source (output valid, kind, dev_addr, reg_addr, length, buf_index, data_byte,
                    sda_in, input ready);
    modport sink   (input valid, kind, dev_addr, reg_addr, length, buf_index, data_byte,
                    sda_in, output ready);
endinterface

interface i2cma_rsp_if;
    logic       valid;
    logic       ready;
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       read_last;
    logic       done_res;
    logic       status;

    modport source (output valid, scl, sda_out, busy_res, read_valid, read_byte, read_last,
                    done_res, status, input ready);
    modport sink   (input valid, scl, sda_out, busy_res, read_valid, read_byte, read_last,
                    done_res, status, output ready);
endinterface

// ===== src/i2c_master_register_access.sv =====
// Top level of the I2C register access master: sequencer, write buffer and result queue.
`timescale 1ns / 1ps
//
// Request channel i_req carries one item per transfer: a bus tick (one bit-phase
// of SCL/SDA), a load of one write buffer byte, or a start of a write or read
// burst. Every accepted item yields exactly one result on o_rsp: the SCL level
// and SDA drive after the item, busy, a received byte with its last flag, and
// done with status when STOP completes.
// Results are registered: an item accepted at an edge has its result on o_rsp after
// that edge if the output register is free or drained, else in the skid register.
// One item per cycle while i_req.ready is high; state advances in a single logic pass.
// A two-entry result queue (output register plus skid register) sits between
// the sides: i_req.ready stays high while the skid register is empty, so one
// more item is taken while a result waits; ready drops once both entries hold
// results and rises when o_rsp.ready drains one.
// Reset (i_rst_n low at a clock edge) empties the queue, returns the sequencer
// to idle with both lines released; write buffer contents are kept.

module i2c_master_register_access (
    input  logic               i_clk,
    input  logic               i_rst_n,
    i2cma_req_if.sink          i_req,
    i2cma_rsp_if.source        o_rsp
);

    localparam int LW = i2cma_pkg::LEN_W;
    localparam int IW = i2cma_pkg::IDX_W;
    localparam int BW = i2cma_pkg::BIT_W;
    localparam logic [LW-1:0] MAX_LEN = LW'(i2cma_pkg::MAX_BYTES);

    i2cma_pkg::t_phase  r_phase, n_phase;
    i2cma_pkg::t_stage  r_stage, n_stage;
    logic [BW-1:0]      r_bit_count, n_bit_count;
    logic [7:0]         r_shift, n_shift;
    logic [LW-1:0]      r_bytes_left, n_bytes_left;
    logic               r_is_read, n_is_read;
    logic [6:0]         r_target_addr, n_target_addr;
    logic [7:0]         r_target_reg, n_target_reg;
    logic [LW-1:0]      r_byte_idx, n_byte_idx;
    logic               r_status_pend, n_status_pend;
    logic               r_scl, n_scl;
    logic               r_sda, n_sda;

    logic [7:0]         r_buf [i2cma_pkg::MAX_BYTES];
    logic               buf_we;
    logic [LW-1:0]      rd_idx;
    logic [7:0]         rd_data;

    i2cma_pkg::t_result res;
    i2cma_pkg::t_result r_head, r_skid;
    logic               r_head_valid, r_skid_valid;

    logic               accept;
    logic               pop;
    logic [LW-1:0]      len_sat;
    logic               msb;
    logic               bl_le1;

    assign accept  = i_req.valid && i_req.ready;
    assign pop     = r_head_valid && o_rsp.ready;
    assign msb     = r_shift[7];
    assign bl_le1  = (r_bytes_left <= LW'(1));
    assign len_sat = (i_req.length > MAX_LEN) ? MAX_LEN : i_req.length;

    assign rd_idx  = (r_stage == i2cma_pkg::SG_DATA) ? (r_byte_idx + LW'(1)) : r_byte_idx;
    assign rd_data = (rd_idx < MAX_LEN) ? r_buf[rd_idx[IW-1:0]] : 8'h00;

    assign buf_we  = accept && (i_req.kind == i2cma_pkg::KIND_LOAD)
                     && ({1'b0, i_req.buf_index} < MAX_LEN);

    always_comb begin
        n_phase       = r_phase;
        n_stage       = r_stage;
        n_bit_count   = r_bit_count;
        n_shift       = r_shift;
        n_bytes_left  = r_bytes_left;
        n_is_read     = r_is_read;
        n_target_addr = r_target_addr;
        n_target_reg  = r_target_reg;
        n_byte_idx    = r_byte_idx;
        n_status_pend = r_status_pend;
        n_scl         = r_scl;
        n_sda         = r_sda;
        res           = '0;

        if (i_req.kind == i2cma_pkg::KIND_LOAD) begin
            n_phase = r_phase;
        end else if (i_req.kind == i2cma_pkg::KIND_WRITE
                     || i_req.kind == i2cma_pkg::KIND_READ) begin
            if (r_phase == i2cma_pkg::PH_IDLE) begin
                n_target_addr = i_req.dev_addr;
                n_target_reg  = i_req.reg_addr;
                n_bytes_left  = len_sat;
                n_is_read     = (i_req.kind == i2cma_pkg::KIND_READ);
                n_stage       = i2cma_pkg::SG_ADDR_W;
                n_byte_idx    = '0;
                n_bit_count   = '0;
                n_shift       = '0;
                n_status_pend = 1'b0;
                n_phase       = i2cma_pkg::PH_ST0;
            end
        end else begin
            unique case (r_phase)
                i2cma_pkg::PH_ST0: begin
                    n_scl = 1'b1; n_sda = 1'b1; n_phase = i2cma_pkg::PH_ST1;
                end
                i2cma_pkg::PH_ST1: begin
                    n_scl = 1'b1; n_sda = 1'b0; n_phase = i2cma_pkg::PH_ST2;
                end
                i2cma_pkg::PH_ST2: begin
                    n_scl       = 1'b0;
                    n_sda       = 1'b0;
                    n_shift     = {r_target_addr, (r_stage == i2cma_pkg::SG_ADDR_R)};
                    n_bit_count = '0;
                    n_phase     = i2cma_pkg::PH_TX0;
                end
                i2cma_pkg::PH_TX0: begin
                    n_scl = 1'b0; n_sda = msb; n_phase = i2cma_pkg::PH_TX1;
                end
                i2cma_pkg::PH_TX1: begin
                    n_scl = 1'b1; n_sda = msb; n_phase = i2cma_pkg::PH_TX2;
                end
                i2cma_pkg::PH_TX2: begin
                    n_scl   = 1'b0;
                    n_shift = {r_shift[6:0], 1'b0};
                    if (r_bit_count >= BW'(7)) begin
                        n_sda       = 1'b1;
                        n_bit_count = '0;
                        n_phase     = i2cma_pkg::PH_AK0;
                    end else begin
                        n_sda       = msb;
                        n_bit_count = r_bit_count + BW'(1);
                        n_phase     = i2cma_pkg::PH_TX0;
                    end
                end
                i2cma_pkg::PH_AK0: begin
                    n_scl = 1'b0; n_sda = 1'b1; n_phase = i2cma_pkg::PH_AK1;
                end
                i2cma_pkg::PH_AK1: begin
                    n_scl = 1'b1; n_sda = 1'b1; n_phase = i2cma_pkg::PH_AK2;
                end
                i2cma_pkg::PH_AK2: begin
                    n_scl = 1'b0;
                    n_sda = 1'b1;
                    unique case (r_stage)
                        i2cma_pkg::SG_ADDR_W: begin
                            if (i_req.sda_in) begin
                                n_status_pend = 1'b1;
                                n_phase       = i2cma_pkg::PH_SP0;
                            end else begin
                                n_stage     = i2cma_pkg::SG_REG;
                                n_shift     = r_target_reg;
                                n_bit_count = '0;
                                n_phase     = i2cma_pkg::PH_TX0;
                            end
                        end
                        i2cma_pkg::SG_REG: begin
                            if (r_is_read) begin
                                n_stage = i2cma_pkg::SG_ADDR_R;
                                n_phase = i2cma_pkg::PH_ST0;
                            end else if (r_bytes_left == '0) begin
                                n_status_pend = 1'b0;
                                n_phase       = i2cma_pkg::PH_SP0;
                            end else begin
                                n_shift     = rd_data;
                                n_bit_count = '0;
                                n_stage     = i2cma_pkg::SG_DATA;
                                n_phase     = i2cma_pkg::PH_TX0;
                            end
                        end
                        i2cma_pkg::SG_DATA: begin
                            if (i_req.sda_in) begin
                                n_status_pend = 1'b1;
                                n_phase       = i2cma_pkg::PH_SP0;
                            end else begin
                                n_bytes_left = (r_bytes_left != '0) ?
                                               (r_bytes_left - LW'(1)) : r_bytes_left;
                                n_byte_idx   = r_byte_idx + LW'(1);
                                if (bl_le1) begin
                                    n_status_pend = 1'b0;
                                    n_phase       = i2cma_pkg::PH_SP0;
                                end else begin
                                    n_shift     = rd_data;
                                    n_bit_count = '0;
                                    n_stage     = i2cma_pkg::SG_DATA;
                                    n_phase     = i2cma_pkg::PH_TX0;
                                end
                            end
                        end
                        i2cma_pkg::SG_ADDR_R: begin
                            if (r_bytes_left == '0) begin
                                n_status_pend = 1'b0;
                                n_phase       = i2cma_pkg::PH_SP0;
                            end else begin
                                n_shift     = '0;
                                n_bit_count = '0;
                                n_phase     = i2cma_pkg::PH_RX0;
                            end
                        end
                        default: begin
                            n_phase = i2cma_pkg::PH_SP0;
                        end
                    endcase
                end
                i2cma_pkg::PH_RX0: begin
                    n_scl = 1'b1; n_sda = 1'b1; n_phase = i2cma_pkg::PH_RX1;
                end
                i2cma_pkg::PH_RX1: begin
                    n_scl   = 1'b0;
                    n_sda   = 1'b1;
                    n_shift = {r_shift[6:0], i_req.sda_in};
                    if (r_bit_count >= BW'(7)) begin
                        n_bit_count    = '0;
                        res.read_valid = 1'b1;
                        res.read_byte  = {r_shift[6:0], i_req.sda_in};
                        res.read_last  = (r_bytes_left == LW'(1));
                        n_phase        = i2cma_pkg::PH_MA0;
                    end else begin
                        n_bit_count = r_bit_count + BW'(1);
                        n_phase     = i2cma_pkg::PH_RX0;
                    end
                end
                i2cma_pkg::PH_MA0: begin
                    n_scl = 1'b0; n_sda = bl_le1; n_phase = i2cma_pkg::PH_MA1;
                end
                i2cma_pkg::PH_MA1: begin
                    n_scl = 1'b1; n_sda = bl_le1; n_phase = i2cma_pkg::PH_MA2;
                end
                i2cma_pkg::PH_MA2: begin
                    n_scl        = 1'b0;
                    n_sda        = bl_le1;
                    n_bytes_left = (r_bytes_left != '0) ?
                                   (r_bytes_left - LW'(1)) : r_bytes_left;
                    if (bl_le1) begin
                        n_status_pend = 1'b0;
                        n_phase       = i2cma_pkg::PH_SP0;
                    end else begin
                        n_shift     = '0;
                        n_bit_count = '0;
                        n_phase     = i2cma_pkg::PH_RX0;
                    end
                end
                i2cma_pkg::PH_SP0: begin
                    n_scl = 1'b1; n_sda = 1'b0; n_phase = i2cma_pkg::PH_SP1;
                end
                i2cma_pkg::PH_SP1: begin
                    n_scl         = 1'b1;
                    n_sda         = 1'b1;
                    res.done_res  = 1'b1;
                    res.status    = r_status_pend;
                    n_status_pend = 1'b0;
                    n_phase       = i2cma_pkg::PH_IDLE;
                end
                default: begin
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                    n_phase = i2cma_pkg::PH_IDLE;
                end
            endcase
        end

        res.scl      = n_scl;
        res.sda_out  = n_sda;
        res.busy_res = (n_phase != i2cma_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= i2cma_pkg::PH_IDLE;
            r_stage       <= i2cma_pkg::SG_ADDR_W;
            r_bit_count   <= '0;
            r_shift       <= '0;
            r_bytes_left  <= '0;
            r_is_read     <= 1'b0;
            r_target_addr <= '0;
            r_target_reg  <= '0;
            r_byte_idx    <= '0;
            r_status_pend <= 1'b0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_stage       <= n_stage;
            r_bit_count   <= n_bit_count;
            r_shift       <= n_shift;
            r_bytes_left  <= n_bytes_left;
            r_is_read     <= n_is_read;
            r_target_addr <= n_target_addr;
            r_target_reg  <= n_target_reg;
            r_byte_idx    <= n_byte_idx;
            r_status_pend <= n_status_pend;
            r_scl         <= n_scl;
            r_sda         <= n_sda;
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            r_buf[i_req.buf_index] <= i_req.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_head_valid <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (!r_head_valid || pop) begin
                r_head_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_head_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_head <= r_skid;
            end
        end else if (accept) begin
            if (!r_head_valid || pop) begin
                r_head <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign i_req.ready      = !r_skid_valid;
    assign o_rsp.valid      = r_head_valid;
    assign o_rsp.scl        = r_head.scl;
    assign o_rsp.sda_out    = r_head.sda_out;
    assign o_rsp.busy_res   = r_head.busy_res;
    assign o_rsp.read_valid = r_head.read_valid;
    assign o_rsp.read_byte  = r_head.read_byte;
    assign o_rsp.read_last  = r_head.read_last;
    assign o_rsp.done_res   = r_head.done_res;
    assign o_rsp.status     = r_head.status;

endmodule
